>>> sv/u2u8_pkg.sv
package u2u8_pkg;

	// Longest run of bytes that one code unit can cause: a replacement
	// character for a dangling high surrogate followed by a three-byte character.
	localparam int unsigned RUN_MAX = 6;
	localparam int unsigned RUN_CNT_W = 3;
	localparam int unsigned RUN_IDX_W = 3;

	typedef logic [7:0] byte_t;

	// One queued job for the back end: the bytes in send order, how many are
	// valid, and whether the unit that caused them ends the string.
	typedef struct packed {
		byte_t [RUN_MAX-1:0]  bytes;
		logic [RUN_CNT_W-1:0] count;
		logic                 last_unit;
	} run_t;

endpackage

>>> sv/u2u8_front.sv
module u2u8_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [15:0]     code_unit,
	input  logic            final_unit,
	input  logic            unit_valid,
	output logic            unit_stall,
	input  logic            queue_full,
	output logic            run_push,
	output u2u8_pkg::run_t  run
);
	import u2u8_pkg::*;

	localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
	localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;
	localparam logic [5:0]  TAG_HIGH       = 6'b110110;
	localparam logic [5:0]  TAG_LOW        = 6'b110111;
	localparam byte_t       REPL_B0        = 8'hEF;
	localparam byte_t       REPL_B1        = 8'hBF;
	localparam byte_t       REPL_B2        = 8'hBD;

	logic        pending_q;
	logic [9:0]  high_q;

	logic        accept;
	logic        is_high;
	logic        is_low;
	logic        pair;
	logic        lead_repl;
	logic        emit_cp;
	logic [20:0] cp;
	byte_t [3:0] enc;
	logic [2:0]  enc_len;
	logic [2:0]  cp_len;

	assign unit_stall = queue_full;
	assign accept     = unit_valid && !queue_full;
	assign is_high    = code_unit[15:10] == TAG_HIGH;
	assign is_low     = code_unit[15:10] == TAG_LOW;
	assign pair       = pending_q && is_low;
	assign lead_repl  = pending_q && !is_low;
	// A high surrogate that is not the last unit is only remembered.
	assign emit_cp    = !(is_high && !final_unit);
	assign cp_len     = emit_cp ? enc_len : 3'd0;

	always_comb begin
		if (pair) begin
			cp = CP_SUPP_BASE + {1'b0, high_q, code_unit[9:0]};
		end else if (is_high || is_low) begin
			cp = CP_REPLACEMENT;
		end else begin
			cp = {5'd0, code_unit};
		end
	end

	always_comb begin
		enc = '0;
		priority if (cp[20:7] == '0) begin
			enc[0]  = {1'b0, cp[6:0]};
			enc_len = 3'd1;
		end else if (cp[20:11] == '0) begin
			enc[0]  = {3'b110, cp[10:6]};
			enc[1]  = {2'b10, cp[5:0]};
			enc_len = 3'd2;
		end else if (cp[20:16] == '0) begin
			enc[0]  = {4'b1110, cp[15:12]};
			enc[1]  = {2'b10, cp[11:6]};
			enc[2]  = {2'b10, cp[5:0]};
			enc_len = 3'd3;
		end else begin
			enc[0]  = {5'b11110, cp[20:18]};
			enc[1]  = {2'b10, cp[17:12]};
			enc[2]  = {2'b10, cp[11:6]};
			enc[3]  = {2'b10, cp[5:0]};
			enc_len = 3'd4;
		end
	end

	// A leading replacement only ever precedes a character of at most three
	// bytes, since a four-byte character needs the pending surrogate itself.
	always_comb begin
		run.bytes     = '0;
		run.last_unit = final_unit;
		if (lead_repl) begin
			run.bytes[0] = REPL_B0;
			run.bytes[1] = REPL_B1;
			run.bytes[2] = REPL_B2;
			run.bytes[3] = enc[0];
			run.bytes[4] = enc[1];
			run.bytes[5] = enc[2];
			run.count    = 3'd3 + cp_len;
		end else begin
			run.bytes[0] = enc[0];
			run.bytes[1] = enc[1];
			run.bytes[2] = enc[2];
			run.bytes[3] = enc[3];
			run.count    = cp_len;
		end
	end

	assign run_push = accept && (run.count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			high_q    <= '0;
		end else if (accept) begin
			pending_q <= !pair && is_high && !final_unit;
			high_q    <= code_unit[9:0];
		end
	end

	a_final_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		accept && final_unit |=> !pending_q)
		else $error("surrogate still pending after the last unit of a string");

endmodule

>>> sv/u2u8_queue.sv
module u2u8_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  u2u8_pkg::run_t run_in,
	output logic           full,
	output logic           head_valid,
	output u2u8_pkg::run_t head,
	input  logic           pop
);
	import u2u8_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	run_t          slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full       = cnt_q == CW'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= run_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("run written into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid))
		else $error("run taken from an empty queue");

endmodule

>>> sv/u2u8_back.sv
module u2u8_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  u2u8_pkg::run_t head,
	output logic           pop,
	output logic           byte_valid,
	input  logic           byte_stall,
	output logic [7:0]     utf8_byte,
	output logic           run_end,
	output logic           string_end
);
	import u2u8_pkg::*;

	logic [RUN_IDX_W-1:0] idx_q;
	logic                 out_valid_q;
	byte_t                byte_q;
	logic                 run_end_q;
	logic                 string_end_q;

	logic                 load;
	logic                 last_byte;

	// The output register refills whenever a run is queued and the register is empty or being drained.
	assign load      = head_valid && (!out_valid_q || !byte_stall);
	assign last_byte = idx_q == (head.count - 3'd1);
	assign pop       = load && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last_byte ? '0 : idx_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!byte_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q       <= head.bytes[idx_q];
			run_end_q    <= last_byte;
			string_end_q <= last_byte && head.last_unit;
		end
	end

	assign byte_valid = out_valid_q;
	assign utf8_byte  = byte_q;
	assign run_end    = run_end_q;
	assign string_end = string_end_q;

	a_run_size: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (head.count != '0) && (head.count <= 3'(RUN_MAX)))
		else $error("queued run has an impossible byte count");

	a_index_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q < head.count)
		else $error("byte index ran past the end of its run");

	a_string_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && string_end_q |-> run_end_q)
		else $error("string end flagged on a byte that does not end its run");

endmodule

>>> sv/utf16_to_utf8_transcoder_core.sv
// UTF-16 to UTF-8 transcoder.
// The unit channel (unit_valid, unit_stall, code_unit, final_unit) takes one
// UTF-16 code unit per transfer; final_unit marks the last unit of a string.
// The byte channel (byte_valid, byte_stall, utf8_byte, run_end, string_end)
// gives one UTF-8 byte per transfer. run_end marks the last byte caused by a
// unit, and string_end the last byte of the string.
// A high surrogate alone causes no bytes until its partner arrives; unpaired
// surrogates come out as U+FFFD. One unit causes zero to six bytes.
// The front end classifies and encodes a unit in the cycle it is taken and
// writes the whole run into a queue of QUEUE_DEPTH runs. The back end sends
// one byte per cycle from the head of that queue while byte_stall is low; a
// unit gives one to three bytes for most characters, up to six. Each run is
// registered in a queue slot, and each of its bytes then in the output
// register. unit_stall is raised only while the queue is full, so units
// keep flowing while a finished byte waits at the output.
// When the receiver raises byte_stall, the output byte holds and the queue
// fills, after which unit_stall rises. Reset empties the queue and drops any
// pending surrogate.
module utf16_to_utf8_transcoder_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        unit_valid,
	output logic        unit_stall,
	input  logic [15:0] code_unit,
	input  logic        final_unit,
	output logic        byte_valid,
	input  logic        byte_stall,
	output logic [7:0]  utf8_byte,
	output logic        run_end,
	output logic        string_end
);
	import u2u8_pkg::*;

	run_t front_run;
	run_t head_run;
	logic run_push;
	logic queue_full;
	logic head_valid;
	logic run_pop;

	// Front end: surrogate pairing and encoding of one unit into a byte run.
	u2u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_unit  (code_unit),
		.final_unit (final_unit),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.queue_full (queue_full),
		.run_push   (run_push),
		.run        (front_run)
	);

	// The queue lets the front end keep taking units while bytes drain.
	u2u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (run_push),
		.run_in     (front_run),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head_run),
		.pop        (run_pop)
	);

	// Back end: serializes each run through the registered byte output.
	u2u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head_run),
		.pop        (run_pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.utf8_byte  (utf8_byte),
		.run_end    (run_end),
		.string_end (string_end)
	);

endmodule
